// File: sv/midi_track_event_parser_macros.svh
// Assertion macros for the MIDI track event parser checker.
// Depends on nothing; the including module provides clk_i and rst_ni.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mtep_pkg.sv
// Shared types, constants and decode functions of the MIDI track event parser.
// Depends on nothing; used by the parser, timer, top level and checker.
`default_nettype none

package mtep_pkg;

  localparam int unsigned SPT_W   = 31;
  localparam int unsigned DELTA_W = 28;
  localparam int unsigned PROD_W  = SPT_W + DELTA_W;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [SPT_W-1:0] SPT_RESET = 31'd15052800;

  localparam logic [1:0] KIND_EVENT   = 2'd0;
  localparam logic [1:0] KIND_BAD_TAG = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] STAT_META       = 8'hFF;
  localparam logic [7:0] STAT_SYSEX      = 8'hF0;
  localparam logic [7:0] STAT_SYSEX_CONT = 8'hF7;
  localparam logic [7:0] STAT_QFRAME     = 8'hF1;
  localparam logic [7:0] STAT_SONG_POS   = 8'hF2;
  localparam logic [7:0] STAT_SONG_SEL   = 8'hF3;

  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROGRAM  = 4'hC;
  localparam logic [3:0] NIB_PRESSURE = 4'hD;
  localparam logic [3:0] NIB_PITCH    = 4'hE;

  // One parsed byte on its way to the time accumulator.
  typedef struct packed {
    logic               clr;
    logic [DELTA_W-1:0] delta;
    logic               emit;
    logic [1:0]         kind;
    logic [7:0]         status;
    logic [7:0]         data1;
    logic [7:0]         data2;
  } evt_t;

  // Expected chunk tag "MTrk".
  function automatic logic [7:0] tag_byte(input logic [1:0] idx);
    logic [7:0] t;
    case (idx)
      2'd0:    t = 8'h4D;
      2'd1:    t = 8'h54;
      2'd2:    t = 8'h72;
      default: t = 8'h6B;
    endcase
    return t;
  endfunction

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_len(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s[7:4] == NIB_PROGRAM || s[7:4] == NIB_PRESSURE) begin
      n = 2'd1;
    end else if (s[7:4] >= NIB_NOTE_OFF && s[7:4] <= NIB_PITCH) begin
      n = 2'd2;
    end else if (s == STAT_QFRAME || s == STAT_SONG_SEL) begin
      n = 2'd1;
    end else if (s == STAT_SONG_POS) begin
      n = 2'd2;
    end
    return n;
  endfunction

  function automatic logic is_reported(input logic [7:0] s);
    return s[7:4] == NIB_NOTE_OFF || s[7:4] == NIB_NOTE_ON || s[7:4] == NIB_CTRL;
  endfunction

endpackage

`default_nettype wire

// File: sv/midi_track_event_parser.sv
// Top level of the MIDI track event parser: configuration register and the
// parser and timer stages. Depends on mtep_pkg, mtep_parser and mtep_timer.
//
//   Channel   Direction  Handshake             Payload
//   in        input      in_valid_i/in_stall_o track_byte_i, track_start_i
//   out       output     out_valid_o/out_stall_i kind_o, sample_time_o, status_byte_o,
//                                              first_data_o, second_data_o
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_samples_per_tick_i
//
// One track byte is accepted every cycle while in_stall_o is low; a result passes
// through the input register, the parser's event register, the registered 28 by 31
// bit product and the saturating time add in front of the result register.
// Reset clears all parser state and sets samples per tick to 229.6875; there is
// no clearing pass. A stalled result holds its register while bytes that cause
// no result keep flowing behind it.
`default_nettype none

module midi_track_event_parser (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 track_byte_i,
  input  wire logic                       track_start_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [31:0]                     sample_time_o,
  output logic [7:0]                      status_byte_o,
  output logic [7:0]                      first_data_o,
  output logic [7:0]                      second_data_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mtep_pkg::SPT_W-1:0] cfg_samples_per_tick_i
);

  logic [mtep_pkg::SPT_W-1:0] spt_q;
  logic                       evt_valid, evt_ready;
  mtep_pkg::evt_t             evt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spt_q <= mtep_pkg::SPT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      spt_q <= cfg_samples_per_tick_i;
    end
  end

  mtep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .track_byte_i (track_byte_i),
    .track_start_i(track_start_i),
    .evt_valid_o  (evt_valid),
    .evt_o        (evt),
    .evt_ready_i  (evt_ready)
  );

  mtep_timer u_timer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_valid_i  (evt_valid),
    .evt_i        (evt),
    .evt_ready_o  (evt_ready),
    .spt_i        (spt_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .sample_time_o(sample_time_o),
    .status_byte_o(status_byte_o),
    .first_data_o (first_data_o),
    .second_data_o(second_data_o)
  );

endmodule

`default_nettype wire

// File: sv/mtep_parser.sv
// Byte-level track parser: input register, tag and length check, delta times,
// running status and skips. Depends on mtep_pkg; feeds mtep_timer.
`default_nettype none

module mtep_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    track_byte_i,
  input  wire logic          track_start_i,
  output logic               evt_valid_o,
  output mtep_pkg::evt_t     evt_o,
  input  wire logic          evt_ready_i
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_TAG, PH_LEN, PH_DELTA, PH_STATUS,
    PH_META_TYPE, PH_SKIP_LEN, PH_SKIP, PH_DATA
  } phase_e;

  phase_e ph_q, ph_d;
  logic [31:0] br_q, br_d;
  logic [mtep_pkg::DELTA_W-1:0] acc_q, acc_d, acc_n;
  logic [2:0]  hc_q, hc_d;
  logic [7:0]  rs_q, rs_d;
  logic        rk_q, rk_d;
  logic [7:0]  pd_q [2];
  logic [7:0]  pd_d [2];
  logic [1:0]  dn_q, dn_d;
  logic [31:0] skip_q, skip_d;

  logic        v0_q, v1_q;
  logic [7:0]  byte_q;
  logic        start_q;
  mtep_pkg::evt_t evt_q, evt_d;

  logic        ready0, ready1, fire;
  logic [1:0]  total, idx;
  logic        ev_sent;

  assign ready1      = !v1_q || evt_ready_i;
  assign ready0      = !v0_q || ready1;
  assign fire        = v0_q && ready1;
  assign in_stall_o  = !ready0;
  assign evt_valid_o = v1_q;
  assign evt_o       = evt_q;

  always_comb begin
    ph_d    = ph_q;
    br_d    = br_q;
    acc_d   = acc_q;
    hc_d    = hc_q;
    rs_d    = rs_q;
    rk_d    = rk_q;
    pd_d    = pd_q;
    dn_d    = dn_q;
    skip_d  = skip_q;
    evt_d   = '0;
    ev_sent = 1'b0;
    acc_n   = '0;
    total   = '0;
    idx     = '0;

    evt_d.clr  = start_q;
    evt_d.kind = mtep_pkg::KIND_EVENT;

    if (start_q) begin
      ph_d  = PH_TAG;
      hc_d  = '0;
      rs_d  = '0;
      rk_d  = 1'b0;
      acc_d = '0;
      dn_d  = '0;
    end

    case (ph_d)
      PH_IDLE: begin
      end
      PH_TAG: begin
        if (byte_q != mtep_pkg::tag_byte(hc_d[1:0])) begin
          ph_d       = PH_IDLE;
          evt_d.emit = 1'b1;
          evt_d.kind = mtep_pkg::KIND_BAD_TAG;
        end else begin
          if (hc_d == 3'd3) begin
            ph_d = PH_LEN;
            br_d = '0;
          end
          hc_d = hc_d + 3'd1;
        end
      end
      PH_LEN: begin
        br_d = {br_d[23:0], byte_q};
        if (hc_d == 3'd7) begin
          hc_d  = '0;
          acc_d = '0;
          ph_d  = PH_DELTA;
          if (br_d == '0) begin
            ph_d       = PH_IDLE;
            evt_d.emit = 1'b1;
            evt_d.kind = mtep_pkg::KIND_END;
          end
        end else begin
          hc_d = hc_d + 3'd1;
        end
      end
      default: begin
        br_d  = br_d - 32'd1;
        acc_n = {acc_d[mtep_pkg::DELTA_W-8:0], byte_q[6:0]};
        case (ph_d)
          PH_DELTA: begin
            acc_d = acc_n;
            if (!byte_q[7]) begin
              evt_d.delta = acc_n;
              acc_d       = '0;
              ph_d        = PH_STATUS;
            end
          end
          PH_STATUS: begin
            if (byte_q == mtep_pkg::STAT_META) begin
              rs_d = byte_q;
              rk_d = 1'b0;
              ph_d = PH_META_TYPE;
            end else if (byte_q == mtep_pkg::STAT_SYSEX ||
                         byte_q == mtep_pkg::STAT_SYSEX_CONT) begin
              rs_d  = byte_q;
              rk_d  = 1'b0;
              acc_d = '0;
              ph_d  = PH_SKIP_LEN;
            end else if (byte_q[7]) begin
              rs_d = byte_q;
              rk_d = (byte_q[7:4] != 4'hF);
              dn_d = mtep_pkg::data_len(byte_q);
              ph_d = (dn_d != '0) ? PH_DATA : PH_DELTA;
            end else if (rk_d) begin
              pd_d[0] = byte_q;
              dn_d    = mtep_pkg::data_len(rs_d) - 2'd1;
              ph_d    = (dn_d != '0) ? PH_DATA : PH_DELTA;
            end else if (rs_d == mtep_pkg::STAT_META) begin
              ph_d = PH_META_TYPE;
            end else if (rs_d == mtep_pkg::STAT_SYSEX ||
                         rs_d == mtep_pkg::STAT_SYSEX_CONT) begin
              acc_d = '0;
              ph_d  = PH_SKIP_LEN;
            end else begin
              ph_d = PH_DELTA;
            end
          end
          PH_META_TYPE: begin
            acc_d = '0;
            ph_d  = PH_SKIP_LEN;
          end
          PH_SKIP_LEN: begin
            acc_d = acc_n;
            if (!byte_q[7]) begin
              skip_d = {4'd0, acc_n};
              acc_d  = '0;
              ph_d   = (acc_n != '0) ? PH_SKIP : PH_DELTA;
            end
          end
          PH_SKIP: begin
            skip_d = skip_d - 32'd1;
            if (skip_d == '0) begin
              ph_d = PH_DELTA;
            end
          end
          PH_DATA: begin
            total = mtep_pkg::data_len(rs_d);
            idx   = (total > dn_d) ? total - dn_d : 2'd0;
            pd_d[idx[0]] = byte_q;
            dn_d  = (dn_d != '0) ? dn_d - 2'd1 : 2'd0;
            if (dn_d == '0) begin
              ph_d = PH_DELTA;
              if (rk_d && total == 2'd2 && mtep_pkg::is_reported(rs_d)) begin
                if (br_d == '0) begin
                  ph_d = PH_IDLE;
                end
                ev_sent      = 1'b1;
                evt_d.emit   = 1'b1;
                evt_d.kind   = mtep_pkg::KIND_EVENT;
                evt_d.status = rs_d;
                evt_d.data1  = pd_d[0];
                evt_d.data2  = pd_d[1];
              end
            end
          end
          default: begin
          end
        endcase
        if (!ev_sent && br_d == '0) begin
          ph_d       = PH_IDLE;
          evt_d.emit = 1'b1;
          evt_d.kind = mtep_pkg::KIND_END;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      br_q    <= '0;
      acc_q   <= '0;
      hc_q    <= '0;
      rs_q    <= '0;
      rk_q    <= 1'b0;
      pd_q[0] <= '0;
      pd_q[1] <= '0;
      dn_q    <= '0;
      skip_q  <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      byte_q  <= '0;
      start_q <= 1'b0;
      evt_q   <= '0;
    end else begin
      if (ready0) begin
        v0_q <= in_valid_i;
        if (in_valid_i) begin
          byte_q  <= track_byte_i;
          start_q <= track_start_i;
        end
      end
      if (ready1) begin
        v1_q  <= v0_q;
        evt_q <= evt_d;
      end
      if (fire) begin
        ph_q   <= ph_d;
        br_q   <= br_d;
        acc_q  <= acc_d;
        hc_q   <= hc_d;
        rs_q   <= rs_d;
        rk_q   <= rk_d;
        pd_q   <= pd_d;
        dn_q   <= dn_d;
        skip_q <= skip_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/mtep_timer.sv
// Tick-to-sample time accumulator and result register: a registered
// delta times samples-per-tick product, then a saturating add. Depends on mtep_pkg.
`default_nettype none

module mtep_timer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       evt_valid_i,
  input  wire mtep_pkg::evt_t             evt_i,
  output logic                            evt_ready_o,
  input  wire logic [mtep_pkg::SPT_W-1:0] spt_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [31:0]                     sample_time_o,
  output logic [7:0]                      status_byte_o,
  output logic [7:0]                      first_data_o,
  output logic [7:0]                      second_data_o
);

  localparam int unsigned PW = mtep_pkg::PROD_W;
  localparam int unsigned FW = mtep_pkg::FRAC_W;
  localparam int unsigned WW = PW - FW;

  logic          v2_q;
  logic [PW-1:0] prod_q;
  logic          clr2_q, emit2_q;
  logic [1:0]    kind2_q;
  logic [7:0]    st2_q, d1_2_q, d2_2_q;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [31:0]   time_q;
  logic [7:0]    st_q, d1_q, d2_q;
  logic [31:0]   abs_q, abs_d, abs_base;
  logic [FW-1:0] frac_q, frac_base;

  logic          ready_out, cons2, ready2;
  logic [FW:0]   lo_sum;
  logic [WW:0]   whole;

  assign ready_out   = !out_valid_q || !out_stall_i;
  assign cons2       = !emit2_q || ready_out;
  assign ready2      = !v2_q || cons2;
  assign evt_ready_o = ready2;

  always_comb begin
    abs_base  = clr2_q ? 32'd0 : abs_q;
    frac_base = clr2_q ? '0 : frac_q;
    lo_sum    = {1'b0, prod_q[FW-1:0]} + {1'b0, frac_base};
    whole     = (WW + 1)'(abs_base) + {1'b0, prod_q[PW-1:FW]} + (WW + 1)'(lo_sum[FW]);
    abs_d     = (whole[WW:32] != '0) ? 32'hFFFF_FFFF : whole[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q        <= 1'b0;
      clr2_q      <= 1'b0;
      emit2_q     <= 1'b0;
      out_valid_q <= 1'b0;
      abs_q       <= '0;
      frac_q      <= '0;
    end else begin
      if (ready2) begin
        v2_q    <= evt_valid_i;
        clr2_q  <= evt_valid_i && evt_i.clr;
        emit2_q <= evt_valid_i && evt_i.emit;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (v2_q && cons2) begin
        abs_q  <= abs_d;
        frac_q <= lo_sum[FW-1:0];
        if (emit2_q) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      prod_q  <= PW'(evt_i.delta) * PW'(spt_i);
      kind2_q <= evt_i.kind;
      st2_q   <= evt_i.status;
      d1_2_q  <= evt_i.data1;
      d2_2_q  <= evt_i.data2;
    end
    if (v2_q && emit2_q && ready_out) begin
      kind_q <= kind2_q;
      time_q <= (kind2_q == mtep_pkg::KIND_BAD_TAG) ? 32'd0 : abs_d;
      st_q   <= st2_q;
      d1_q   <= d1_2_q;
      d2_q   <= d2_2_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign sample_time_o = time_q;
  assign status_byte_o = st_q;
  assign first_data_o  = d1_q;
  assign second_data_o = d2_q;

endmodule

`default_nettype wire

// File: sv/mtep_checker.sv
// Port-level checks of the MIDI track event parser, bound to its top level.
// Depends on mtep_pkg and midi_track_event_parser_macros.svh.
`default_nettype none
`include "midi_track_event_parser_macros.svh"

module mtep_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  kind_o,
  input wire logic [31:0] sample_time_o,
  input wire logic [7:0]  status_byte_o,
  input wire logic [7:0]  first_data_o,
  input wire logic [7:0]  second_data_o
);

  `MTEP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(kind_o) && $stable(sample_time_o) && $stable(status_byte_o),
    "stalled result request changed")

  `MTEP_ASSERT_IMP(a_status_zero, out_valid_o && kind_o != mtep_pkg::KIND_EVENT,
    status_byte_o == 8'd0 && first_data_o == 8'd0 && second_data_o == 8'd0,
    "non-event request carries message bytes")

  `MTEP_ASSERT_IMP(a_bad_tag_time, out_valid_o && kind_o == mtep_pkg::KIND_BAD_TAG,
    sample_time_o == 32'd0,
    "bad tag request carries a time")

  `MTEP_ASSERT_IMP(a_event_status, out_valid_o && kind_o == mtep_pkg::KIND_EVENT,
    status_byte_o[7:4] == mtep_pkg::NIB_NOTE_OFF || status_byte_o[7:4] == mtep_pkg::NIB_NOTE_ON ||
    status_byte_o[7:4] == mtep_pkg::NIB_CTRL,
    "event request with an unreported status")

endmodule

bind midi_track_event_parser mtep_checker u_checker (.*);

`default_nettype wire
